@@ rtl/core/eatrm_pkg.sv @@
// Package for the Euler-angle to 3x4 transform block.
// Holds the fixed-point formats, the arctangent table and rounding helpers.
// Depends on nothing.
package eatrm_pkg;

    // Widths of the coefficient path and length of the CORDIC chain.
    localparam int CoefWidth    = 16;
    localparam int CordicStages = 16;
    localparam int FracBits     = CoefWidth - 2;
    localparam int AtanEntries  = 30;

    // Angle path: units of 2^-16 of 1/64 degree, 16 bit angle plus 16 bits.
    localparam int ZW = 34;
    // CORDIC x and y width: gain below one plus growth, plus guard.
    localparam int XW = CoefWidth + 2;
    // Products of two coefficients.
    localparam int PW = 2 * XW;

    localparam int TurnUnits    = 23040;
    localparam int HalfUnits    = 11520;
    localparam int QuarterUnits = 5760;
    localparam int ThreeQUnits  = 17280;
    localparam int EntryMax     = 16384;

    localparam longint GainQ30 = 64'sd652032874;

    typedef logic signed [XW-1:0] coef_t;
    typedef logic signed [ZW-1:0] ang_t;

    // State carried by one CORDIC cell.
    typedef struct packed {
        logic  neg;
        coef_t x;
        coef_t y;
        ang_t  z;
    } cordic_word_t;

    // Round to nearest, halves away from zero, by a right shift of s.
    function automatic longint round_shift(input longint v, input int s);
        longint half;
        longint r;
        begin
            r = v;
            if (s > 0)
            begin
                half = longint'(1) <<< (s - 1);
                if (v >= 0)
                    r = (v + half) >>> s;
                else
                    r = -((-v + half) >>> s);
            end
            return r;
        end
    endfunction

    // Starting x of the rotation: the CORDIC gain at FracBits.
    function automatic coef_t gain_init();
        longint g;
        begin
            if (FracBits >= 30)
                g = GainQ30;
            else
                g = round_shift(GainQ30, 30 - FracBits);
            return coef_t'(g);
        end
    endfunction

    // Arctangent of 2^-i in degrees times 2^22.
    function automatic ang_t atan_entry(input int i);
        ang_t r;
        begin
            case (i)
                0: r = ang_t'(188743680);
                1: r = ang_t'(111421900);
                2: r = ang_t'(58872272);
                3: r = ang_t'(29884485);
                4: r = ang_t'(15000234);
                5: r = ang_t'(7507429);
                6: r = ang_t'(3754631);
                7: r = ang_t'(1877430);
                8: r = ang_t'(938729);
                9: r = ang_t'(469366);
                10: r = ang_t'(234683);
                11: r = ang_t'(117342);
                12: r = ang_t'(58671);
                13: r = ang_t'(29335);
                14: r = ang_t'(14668);
                15: r = ang_t'(7334);
                16: r = ang_t'(3667);
                17: r = ang_t'(1833);
                18: r = ang_t'(917);
                19: r = ang_t'(458);
                20: r = ang_t'(229);
                21: r = ang_t'(115);
                22: r = ang_t'(57);
                23: r = ang_t'(29);
                24: r = ang_t'(14);
                25: r = ang_t'(7);
                26: r = ang_t'(4);
                27: r = ang_t'(2);
                28: r = ang_t'(1);
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // Product of two coefficients rounded back to FracBits.
    function automatic coef_t fmul(input coef_t a, input coef_t b);
        logic signed [PW-1:0] p;
        begin
            p = PW'(a) * PW'(b);
            return coef_t'(round_shift(longint'(p), FracBits));
        end
    endfunction

    // Convert to Q1.14 and saturate to plus or minus one.
    function automatic logic signed [15:0] to_q14(input logic signed [XW+1:0] v);
        longint r;
        begin
            if (FracBits >= 14)
                r = round_shift(longint'(v), FracBits - 14);
            else
                r = longint'(v) <<< (14 - FracBits);
            if (r > EntryMax)
                r = EntryMax;
            if (r < -EntryMax)
                r = -EntryMax;
            return 16'(r);
        end
    endfunction

endpackage

@@ rtl/core/eatrm_reduce.sv @@
// Angle reduction: folds a 16 bit angle into [-90, +90] degrees.
// Uses eatrm_pkg. One registered stage that feeds the first CORDIC cell.
module eatrm_reduce
(
    input  logic                 clk,
    input  logic signed [15:0]   angle,
    output eatrm_pkg::cordic_word_t word
);

    logic signed [15:0] m;
    logic signed [15:0] a;
    logic               neg;
    eatrm_pkg::cordic_word_t word_reg;
    eatrm_pkg::cordic_word_t word_next;

    // Modulo one turn: the input spans under three turns each way, so
    // a few compares replace the remainder.
    always_comb
    begin
        m = angle;
        if (m >= 16'sd23040)
            m = m - 16'sd23040;
        else if (m < -16'sd23040)
            m = m + 16'sd23040 + 16'sd23040;
        else if (m < 16'sd0)
            m = m + 16'sd23040;
        neg = 1'b0;
        a   = m;
        if (m > 16'(eatrm_pkg::ThreeQUnits))
            a = m - 16'(eatrm_pkg::TurnUnits);
        else if (m > 16'(eatrm_pkg::QuarterUnits))
        begin
            a   = m - 16'(eatrm_pkg::HalfUnits);
            neg = 1'b1;
        end
        word_next.neg = neg;
        word_next.x   = eatrm_pkg::gain_init();
        word_next.y   = '0;
        word_next.z   = {{(eatrm_pkg::ZW-32){a[15]}}, a, 16'h0000};
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

@@ rtl/core/eatrm_cell.sv @@
// One CORDIC rotation cell: a single micro-rotation and its register.
// Uses eatrm_pkg. Shift and arctangent follow from the cell's place.
module eatrm_cell
(
    input  logic                    clk,
    input  logic [4:0]              stage,
    input  eatrm_pkg::cordic_word_t din,
    output eatrm_pkg::cordic_word_t dout
);

    eatrm_pkg::cordic_word_t dout_reg;
    eatrm_pkg::cordic_word_t dout_next;
    eatrm_pkg::coef_t        dx;
    eatrm_pkg::coef_t        dy;

    // Rotate towards zero residual angle; shifts floor.
    always_comb
    begin
        dx = din.y >>> stage;
        dy = din.x >>> stage;
        dout_next.neg = din.neg;
        if (!din.z[eatrm_pkg::ZW-1])
        begin
            dout_next.x = din.x - dx;
            dout_next.y = din.y + dy;
            dout_next.z = din.z - eatrm_pkg::atan_entry(int'(stage));
        end
        else
        begin
            dout_next.x = din.x + dx;
            dout_next.y = din.y - dy;
            dout_next.z = din.z + eatrm_pkg::atan_entry(int'(stage));
        end
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

@@ rtl/core/eatrm_chain.sv @@
// Row of CORDIC cells forming sine and cosine of one angle.
// Uses eatrm_pkg, eatrm_reduce and eatrm_cell.
module eatrm_chain
(
    input  logic                      clk,
    input  logic signed [15:0]        angle,
    output eatrm_pkg::coef_t          sin_val,
    output eatrm_pkg::coef_t          cos_val
);

    eatrm_pkg::cordic_word_t link [0:eatrm_pkg::CordicStages];

    eatrm_reduce u_reduce
    (
        .clk   (clk),
        .angle (angle),
        .word  (link[0])
    );

    // One cell per stage, each handing its word to the next.
    for (genvar i = 0; i < eatrm_pkg::CordicStages; i++)
    begin : g_cell
        eatrm_cell u_cell
        (
            .clk   (clk),
            .stage (5'(i)),
            .din   (link[i]),
            .dout  (link[i+1])
        );
    end

    // Undo the half-turn fold.
    assign sin_val = link[eatrm_pkg::CordicStages].neg ?
                     -link[eatrm_pkg::CordicStages].y : link[eatrm_pkg::CordicStages].y;
    assign cos_val = link[eatrm_pkg::CordicStages].neg ?
                     -link[eatrm_pkg::CordicStages].x : link[eatrm_pkg::CordicStages].x;

endmodule

@@ rtl/core/euler_angles_to_rotation_matrix_top.sv @@
// Top level of the Euler-angle to 3x4 transform block.
// Uses eatrm_pkg and eatrm_chain (three CORDIC chains and a product pipeline).
//
// Channel  | Handshake        | Words
// input    | start, busy      | pitch/yaw/roll_angle, pos_x/y/z
// result   | done (strobe)    | m00..m22, m03, m13, m23
//
// One word is taken every cycle; busy is always low.
// The path registers the reduction, each CORDIC cell, then three product stages
// and the output register.
// Reset clears the valid pipeline; payload registers are not reset.
// The receiver cannot stall, so nothing holds the pipeline.
module euler_angles_to_rotation_matrix_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] pitch_angle,
    input  logic signed [15:0] yaw_angle,
    input  logic signed [15:0] roll_angle,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    output logic               done,
    output logic signed [15:0] m00,
    output logic signed [15:0] m10,
    output logic signed [15:0] m20,
    output logic signed [15:0] m01,
    output logic signed [15:0] m11,
    output logic signed [15:0] m21,
    output logic signed [15:0] m02,
    output logic signed [15:0] m12,
    output logic signed [15:0] m22,
    output logic signed [31:0] m03,
    output logic signed [31:0] m13,
    output logic signed [31:0] m23
);

    localparam int Lat = eatrm_pkg::CordicStages + 5;
    localparam int CW  = eatrm_pkg::XW;

    logic [Lat-1:0]    vld_reg;
    logic [Lat-1:0]    vld_next;
    logic signed [95:0] pos_reg [0:Lat-1];

    eatrm_pkg::coef_t sp, cp, sy, cy, sr, cr;

    eatrm_pkg::coef_t s1_sp_reg, s1_cp_reg, s1_sy_reg, s1_cy_reg, s1_sr_reg, s1_cr_reg;
    eatrm_pkg::coef_t s2_sp_reg, s2_m00_reg, s2_m10_reg, s2_m21_reg, s2_m22_reg;
    eatrm_pkg::coef_t s2_crcy_reg, s2_crsy_reg, s2_srcy_reg, s2_srsy_reg;
    logic signed [CW+1:0] s3_reg [0:8];
    logic signed [15:0]   out_reg [0:8];

    assign busy = 1'b0;

    eatrm_chain u_pitch (.clk(clk), .angle(pitch_angle), .sin_val(sp), .cos_val(cp));
    eatrm_chain u_yaw   (.clk(clk), .angle(yaw_angle),   .sin_val(sy), .cos_val(cy));
    eatrm_chain u_roll  (.clk(clk), .angle(roll_angle),  .sin_val(sr), .cos_val(cr));

    // Valid bits travel alongside the words.
    assign vld_next = {vld_reg[Lat-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Position delay line and product stages.
    always_ff @(posedge clk)
    begin
        pos_reg[0] <= {pos_x, pos_y, pos_z};
        for (int i = 1; i < Lat; i++)
            pos_reg[i] <= pos_reg[i-1];

        // Stage one: register the sines and cosines.
        s1_sp_reg <= sp;
        s1_cp_reg <= cp;
        s1_sy_reg <= sy;
        s1_cy_reg <= cy;
        s1_sr_reg <= sr;
        s1_cr_reg <= cr;

        // Stage two: first-level products.
        s2_sp_reg   <= s1_sp_reg;
        s2_m00_reg  <= eatrm_pkg::fmul(s1_cp_reg, s1_cy_reg);
        s2_m10_reg  <= eatrm_pkg::fmul(s1_cp_reg, s1_sy_reg);
        s2_m21_reg  <= eatrm_pkg::fmul(s1_sr_reg, s1_cp_reg);
        s2_m22_reg  <= eatrm_pkg::fmul(s1_cr_reg, s1_cp_reg);
        s2_crcy_reg <= eatrm_pkg::fmul(s1_cr_reg, s1_cy_reg);
        s2_crsy_reg <= eatrm_pkg::fmul(s1_cr_reg, s1_sy_reg);
        s2_srcy_reg <= eatrm_pkg::fmul(s1_sr_reg, s1_cy_reg);
        s2_srsy_reg <= eatrm_pkg::fmul(s1_sr_reg, s1_sy_reg);

        // Stage three: second-level products and sums.
        s3_reg[0] <= (CW+2)'(s2_m00_reg);
        s3_reg[1] <= (CW+2)'(s2_m10_reg);
        s3_reg[2] <= -(CW+2)'(s2_sp_reg);
        s3_reg[3] <= (CW+2)'(eatrm_pkg::fmul(s2_sp_reg, s2_srcy_reg)) - (CW+2)'(s2_crsy_reg);
        s3_reg[4] <= (CW+2)'(eatrm_pkg::fmul(s2_sp_reg, s2_srsy_reg)) + (CW+2)'(s2_crcy_reg);
        s3_reg[5] <= (CW+2)'(s2_m21_reg);
        s3_reg[6] <= (CW+2)'(eatrm_pkg::fmul(s2_sp_reg, s2_crcy_reg)) + (CW+2)'(s2_srsy_reg);
        s3_reg[7] <= (CW+2)'(eatrm_pkg::fmul(s2_sp_reg, s2_crsy_reg)) - (CW+2)'(s2_srcy_reg);
        s3_reg[8] <= (CW+2)'(s2_m22_reg);

        // Output: convert to Q1.14 with saturation.
        for (int k = 0; k < 9; k++)
            out_reg[k] <= eatrm_pkg::to_q14(s3_reg[k]);
    end

    assign done = vld_reg[Lat-1];
    assign m00 = out_reg[0];
    assign m10 = out_reg[1];
    assign m20 = out_reg[2];
    assign m01 = out_reg[3];
    assign m11 = out_reg[4];
    assign m21 = out_reg[5];
    assign m02 = out_reg[6];
    assign m12 = out_reg[7];
    assign m22 = out_reg[8];
    assign m03 = pos_reg[Lat-1][95:64];
    assign m13 = pos_reg[Lat-1][63:32];
    assign m23 = pos_reg[Lat-1][31:0];

endmodule

@@ tb/euler_angles_to_rotation_matrix_top_test.sv @@
// Testbench for the Euler-angle to 3x4 transform block.
// Uses eatrm_pkg for its widths, gain and arctangent table; predicts every word with its own CORDIC model.
`timescale 1ns / 1ps
module euler_angles_to_rotation_matrix_top_test;

    typedef struct {
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [15:0] roll;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } angles_word_t;

    typedef struct {
        logic signed [15:0] m [9];
        logic signed [31:0] t [3];
    } transform_word_t;

    localparam int FracW      = eatrm_pkg::CoefWidth - 2;
    localparam int Stages     = eatrm_pkg::CordicStages;
    localparam int TurnU      = 23040;
    localparam int HalfU      = 11520;
    localparam int QuarterU   = 5760;
    localparam int ThreeQU    = 17280;
    localparam int OneQ14     = 16384;
    localparam int IdleLimit  = 2000;
    localparam int Latency    = Stages + 5;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [15:0] pitch_angle, yaw_angle, roll_angle;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic done;
    logic signed [15:0] m00, m10, m20, m01, m11, m21, m02, m12, m22;
    logic signed [31:0] m03, m13, m23;

    // The driver needs busy as it was at the last rising edge.
    logic busy_at_edge;

    angles_word_t    pending_angles [$];
    transform_word_t expected_transforms [$];
    int  failures;
    int  idle_cycles;
    int  gap_left;
    bit  calm_phase;
    bit  feeding_done;

    euler_angles_to_rotation_matrix_top uut
    (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pitch_angle(pitch_angle), .yaw_angle(yaw_angle), .roll_angle(roll_angle),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .done(done),
        .m00(m00), .m10(m10), .m20(m20), .m01(m01), .m11(m11), .m21(m21),
        .m02(m02), .m12(m12), .m22(m22), .m03(m03), .m13(m13), .m23(m23)
    );

    // Free-running clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Rounds to nearest with halves away from zero.
    function automatic longint rnd_shift(input longint v, input int s);
        longint half;
        begin
            if (s == 0)
                return v;
            half = longint'(1) << (s - 1);
            if (v >= 0)
                return (v + half) >>> s;
            return -((-v + half) >>> s);
        end
    endfunction

    function automatic longint coef_mul(input longint a, input longint b);
        begin
            return rnd_shift(a * b, FracW);
        end
    endfunction

    function automatic logic signed [15:0] sat_q14(input longint v);
        longint r;
        begin
            if (FracW >= 14)
                r = rnd_shift(v, FracW - 14);
            else
                r = v * (longint'(1) << (14 - FracW));
            if (r > OneQ14)
                r = OneQ14;
            if (r < -OneQ14)
                r = -OneQ14;
            return 16'(r);
        end
    endfunction

    // Folds the angle into a half turn and runs the rotation CORDIC.
    task automatic sine_cosine(input logic signed [15:0] ang, output longint s,
                               output longint c);
        longint a, x, y, z, dx, dy;
        bit flip;
        begin
            a = longint'(ang) % TurnU;
            if (a < 0)
                a += TurnU;
            flip = 1'b0;
            if (a > ThreeQU)
                a -= TurnU;
            else if (a > QuarterU)
            begin
                a -= HalfU;
                flip = 1'b1;
            end
            x = (FracW >= 30) ? eatrm_pkg::GainQ30
                              : rnd_shift(eatrm_pkg::GainQ30, 30 - FracW);
            y = 0;
            z = a * 65536;
            for (int i = 0; i < Stages && i < 30; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx;
                    y += dy;
                    z -= longint'(eatrm_pkg::atan_entry(i));
                end
                else
                begin
                    x += dx;
                    y -= dy;
                    z += longint'(eatrm_pkg::atan_entry(i));
                end
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            s = y;
            c = x;
        end
    endtask

    // Works out the whole transform for one word of angles.
    task automatic predict_transform(input angles_word_t w, output transform_word_t r);
        longint sp, cp, sy, cy, sr, cr, crcy, crsy, srcy, srsy;
        begin
            sine_cosine(w.yaw, sy, cy);
            sine_cosine(w.pitch, sp, cp);
            sine_cosine(w.roll, sr, cr);
            crcy = coef_mul(cr, cy);
            crsy = coef_mul(cr, sy);
            srcy = coef_mul(sr, cy);
            srsy = coef_mul(sr, sy);
            r.m[0] = sat_q14(coef_mul(cp, cy));
            r.m[1] = sat_q14(coef_mul(cp, sy));
            r.m[2] = sat_q14(-sp);
            r.m[3] = sat_q14(coef_mul(sp, srcy) - crsy);
            r.m[4] = sat_q14(coef_mul(sp, srsy) + crcy);
            r.m[5] = sat_q14(coef_mul(sr, cp));
            r.m[6] = sat_q14(coef_mul(sp, crcy) + srsy);
            r.m[7] = sat_q14(coef_mul(sp, crsy) - srcy);
            r.m[8] = sat_q14(coef_mul(cr, cp));
            r.t[0] = w.px;
            r.t[1] = w.py;
            r.t[2] = w.pz;
        end
    endtask

    task automatic queue_word(input int p, input int y, input int r,
                              input int x, input int yy, input int z);
        angles_word_t w;
        begin
            w.pitch = 16'(p);
            w.yaw = 16'(y);
            w.roll = 16'(r);
            w.px = 32'(x);
            w.py = 32'(yy);
            w.pz = 32'(z);
            pending_angles.push_back(w);
        end
    endtask

    function automatic int random_angle();
        begin
            case ($urandom_range(0, 3))
                0: return $urandom_range(0, 65535);
                1: return QuarterU * $urandom_range(0, 7) - 2 * TurnU
                          + $urandom_range(0, 2) - 1;
                2: return int'($urandom_range(0, 2 * TurnU)) - TurnU;
                default: return ($urandom_range(0, 1) ? 32767 : -32768);
            endcase
        end
    endfunction

    // Driver: presents the oldest word, with random gaps outside the calm phase.
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && !busy_at_edge)
        begin
            if (gap_left == 0 && pending_angles.size() > 0)
                drive_next();
            else
                start <= 1'b0;
        end
        else if (!start)
        begin
            if (gap_left > 0)
                gap_left <= gap_left - 1;
            else if (pending_angles.size() > 0)
                drive_next();
        end
    end

    always @(posedge clk)
    begin
        busy_at_edge <= busy;
    end

    task automatic drive_next();
        angles_word_t w;
        begin
            w = pending_angles.pop_front();
            start <= 1'b1;
            pitch_angle <= w.pitch;
            yaw_angle <= w.yaw;
            roll_angle <= w.roll;
            pos_x <= w.px;
            pos_y <= w.py;
            pos_z <= w.pz;
            if (!calm_phase && $urandom_range(0, 5) == 0)
                gap_left <= $urandom_range(1, 12);
        end
    endtask

    // Monitor: records accepted words, checks results, and keeps the watchdog.
    always @(posedge clk)
    begin
        angles_word_t    w;
        transform_word_t exp_t, got;
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (start && !busy)
            begin
                w.pitch = pitch_angle;
                w.yaw = yaw_angle;
                w.roll = roll_angle;
                w.px = pos_x;
                w.py = pos_y;
                w.pz = pos_z;
                predict_transform(w, exp_t);
                expected_transforms.push_back(exp_t);
            end
            if (done)
            begin
                got.m = '{m00, m10, m20, m01, m11, m21, m02, m12, m22};
                got.t = '{m03, m13, m23};
                if (expected_transforms.size() == 0)
                begin
                    $error("result word with nothing expected");
                    failures++;
                end
                else
                begin
                    exp_t = expected_transforms.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (got.m[i] !== exp_t.m[i])
                        begin
                            $error("m%0d%0d expected %0d actual %0d", i % 3, i / 3,
                                   exp_t.m[i], got.m[i]);
                            failures++;
                        end
                    for (int i = 0; i < 3; i++)
                        if (got.t[i] !== exp_t.t[i])
                        begin
                            $error("m%0d3 expected %0d actual %0d", i,
                                   exp_t.t[i], got.t[i]);
                            failures++;
                        end
                end
            end
            if (idle_cycles >= IdleLimit)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int edge_angles [10];
        failures = 0;
        idle_cycles = 0;
        gap_left = 0;
        calm_phase = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        pitch_angle = '0;
        yaw_angle = '0;
        roll_angle = '0;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words: zero pose, fold boundaries, extremes, zero position.
        edge_angles = '{0, QuarterU, QuarterU + 1, ThreeQU, ThreeQU + 1,
                        HalfU, -QuarterU, TurnU, 32767, -32768};
        queue_word(0, 0, 0, 0, 0, 0);
        foreach (edge_angles[i])
            queue_word(edge_angles[i], edge_angles[(i + 3) % 10],
                       edge_angles[(i + 7) % 10], 32'h7fffffff, 32'h80000000, -1);
        queue_word(32767, 32767, 32767, 0, 0, 0);
        queue_word(-32768, -32768, -32768, -1, -1, -1);
        queue_word(2880, 2880, -2880, 1, -1, 32'h55555555);
        queue_word(-5760, 5760, 11520, 32'haaaaaaaa, 0, 0);

        // Random words; the last stretch runs with no gaps.
        for (int n = 0; n < 900; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_word(random_angle(), random_angle(), random_angle(), 0, 0, 0);
            else
                queue_word(random_angle(), random_angle(), random_angle(),
                           $urandom, $urandom, $urandom);
            if (n == 800)
            begin
                while (pending_angles.size() > 0)
                    @(posedge clk);
                calm_phase = 1'b1;
            end
        end
        while (pending_angles.size() > 0 || start)
            @(posedge clk);
        while (expected_transforms.size() > 0)
            @(posedge clk);
        repeat (Latency + 4) @(posedge clk);
        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
